FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on clock and disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge.
`define ASSERT_HOLDS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent in a cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/ps2sc_pkg.sv
package ps2sc_pkg;

   localparam int QUEUE_DEPTH = 128;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] SC_RELEASE = 8'hF0;
   localparam logic [7:0] SC_CTRL    = 8'h14;
   localparam logic [7:0] SC_LSHIFT  = 8'h12;
   localparam logic [7:0] SC_RSHIFT  = 8'h59;
   localparam logic [7:0] SC_KEY_D   = 8'h23;
   localparam logic [7:0] SC_NONE    = 8'h00;
   localparam logic [7:0] CH_EOT     = 8'h04;

   typedef struct packed {
      logic       mode;
      logic [7:0] scan_code;
   } req_type;

   typedef struct packed {
      logic       read_valid;
      logic [7:0] read_char;
      logic [7:0] queue_count;
      logic       overflow;
   } rsp_type;

   typedef struct packed {
      logic       push;
      logic [7:0] ch;
   } push_type;

   typedef struct packed {
      logic             read_valid;
      logic [CNT_W-1:0] count;
      logic             overflow;
   } q_status_type;

   function automatic logic [7:0] lower_char(input logic [7:0] code);
      logic [7:0] c;
      case (code)
         8'h15: c = 8'h71;  8'h16: c = 8'h31;  8'h1A: c = 8'h7A;  8'h1B: c = 8'h73;
         8'h1C: c = 8'h61;  8'h1D: c = 8'h77;  8'h1E: c = 8'h32;
         8'h21: c = 8'h63;  8'h22: c = 8'h78;  8'h23: c = 8'h64;  8'h24: c = 8'h65;
         8'h25: c = 8'h34;  8'h26: c = 8'h33;
         8'h29: c = 8'h20;  8'h2A: c = 8'h76;  8'h2B: c = 8'h66;  8'h2C: c = 8'h74;
         8'h2D: c = 8'h72;  8'h2E: c = 8'h35;
         8'h31: c = 8'h6E;  8'h32: c = 8'h62;  8'h33: c = 8'h68;  8'h34: c = 8'h67;
         8'h35: c = 8'h79;  8'h36: c = 8'h36;
         8'h3A: c = 8'h6D;  8'h3B: c = 8'h6A;  8'h3C: c = 8'h75;  8'h3D: c = 8'h37;
         8'h3E: c = 8'h38;
         8'h41: c = 8'h2C;  8'h42: c = 8'h6B;  8'h43: c = 8'h69;  8'h44: c = 8'h6F;
         8'h45: c = 8'h30;  8'h46: c = 8'h39;
         8'h49: c = 8'h2E;  8'h4A: c = 8'h2F;  8'h4B: c = 8'h6C;  8'h4C: c = 8'h3B;
         8'h4D: c = 8'h70;  8'h4E: c = 8'h2D;
         8'h52: c = 8'h27;  8'h54: c = 8'h5B;  8'h55: c = 8'h3D;
         8'h5A: c = 8'h0D;  8'h5B: c = 8'h5D;  8'h5D: c = 8'h5C;
         8'h66: c = 8'h08;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] upper_char(input logic [7:0] code);
      logic [7:0] c;
      case (code)
         8'h15: c = 8'h51;  8'h16: c = 8'h21;  8'h1A: c = 8'h5A;  8'h1B: c = 8'h53;
         8'h1C: c = 8'h41;  8'h1D: c = 8'h57;  8'h1E: c = 8'h40;
         8'h21: c = 8'h43;  8'h22: c = 8'h58;  8'h23: c = 8'h44;  8'h24: c = 8'h45;
         8'h25: c = 8'h24;  8'h26: c = 8'h23;
         8'h29: c = 8'h20;  8'h2A: c = 8'h56;  8'h2B: c = 8'h46;  8'h2C: c = 8'h54;
         8'h2D: c = 8'h52;  8'h2E: c = 8'h25;
         8'h31: c = 8'h4E;  8'h32: c = 8'h42;  8'h33: c = 8'h48;  8'h34: c = 8'h47;
         8'h35: c = 8'h59;  8'h36: c = 8'h5E;
         8'h3A: c = 8'h4D;  8'h3B: c = 8'h4A;  8'h3C: c = 8'h55;  8'h3D: c = 8'h26;
         8'h3E: c = 8'h2A;
         8'h41: c = 8'h3C;  8'h42: c = 8'h4B;  8'h43: c = 8'h49;  8'h44: c = 8'h4F;
         8'h45: c = 8'h29;  8'h46: c = 8'h28;
         8'h49: c = 8'h3E;  8'h4A: c = 8'h3F;  8'h4B: c = 8'h4C;  8'h4C: c = 8'h3A;
         8'h4D: c = 8'h50;  8'h4E: c = 8'h5F;
         8'h52: c = 8'h22;  8'h54: c = 8'h7B;  8'h55: c = 8'h2B;
         8'h5A: c = 8'h0D;  8'h5B: c = 8'h7D;  8'h5D: c = 8'h7C;
         8'h66: c = 8'h08;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/ps2sc_decode.sv
module ps2sc_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          code,
   output ps2sc_pkg::push_type push
);

   logic release_ff, release_in;
   logic shift_ff, shift_in;
   logic ctrl_ff, ctrl_in;
   logic is_shift;

   assign is_shift = (code == ps2sc_pkg::SC_LSHIFT) || (code == ps2sc_pkg::SC_RSHIFT);

   always_comb begin
      release_in = release_ff;
      shift_in   = shift_ff;
      ctrl_in    = ctrl_ff;
      push.push  = 1'b0;
      push.ch    = 8'h00;
      if (code == ps2sc_pkg::SC_CTRL) begin
         if (release_ff) begin
            ctrl_in    = 1'b0;
            release_in = 1'b0;
         end else begin
            ctrl_in = 1'b1;
         end
      end else if (code == ps2sc_pkg::SC_RELEASE) begin
         release_in = 1'b1;
      end else if (release_ff && (code != ps2sc_pkg::SC_NONE)) begin
         release_in = 1'b0;
         if (is_shift) begin
            shift_in = 1'b0;
         end
      end else if (is_shift) begin
         shift_in = 1'b1;
      end else if (shift_ff) begin
         push.push = 1'b1;
         push.ch   = ps2sc_pkg::upper_char(code);
      end else if (!ctrl_ff) begin
         push.push = 1'b1;
         push.ch   = ps2sc_pkg::lower_char(code);
      end else if (code == ps2sc_pkg::SC_KEY_D) begin
         push.push = 1'b1;
         push.ch   = ps2sc_pkg::CH_EOT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         release_ff <= 1'b0;
         shift_ff   <= 1'b0;
         ctrl_ff    <= 1'b0;
      end else if (fire) begin
         release_ff <= release_in;
         shift_ff   <= shift_in;
         ctrl_ff    <= ctrl_in;
      end
   end

endmodule

FILE: rtl/ps2sc_queue.sv
module ps2sc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    fire,
   input  logic                    pop,
   input  ps2sc_pkg::push_type     push,
   output ps2sc_pkg::q_status_type status,
   output logic [7:0]              rd_data_ff
);

   localparam int PW = ps2sc_pkg::PTR_W;
   localparam int CW = ps2sc_pkg::CNT_W;

   logic [7:0]    char_queue_ff [ps2sc_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wptr_ff, wptr_in;
   logic [PW-1:0] rptr_ff, rptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          full, pop_ok, push_ok;

   assign full    = count_ff >= CW'(ps2sc_pkg::QUEUE_DEPTH);
   assign pop_ok  = pop && (count_ff != '0);
   assign push_ok = !pop && push.push && !full;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (pop_ok) begin
         rptr_in  = (rptr_ff == PW'(ps2sc_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end else if (push_ok) begin
         wptr_in  = (wptr_ff == PW'(ps2sc_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
   end

   assign status.read_valid = pop_ok;
   assign status.count      = count_in;
   assign status.overflow   = !pop && push.push && full;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else if (fire) begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && push_ok) begin
         char_queue_ff[wptr_ff] <= push.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && pop_ok) begin
         rd_data_ff <= char_queue_ff[rptr_ff];
      end
   end

endmodule

FILE: rtl/ps2_scan_code_to_ascii_queue_core.sv
// PS/2 set-2 keyboard decoder with a 128-character queue. Each request item is either a scan
// code (mode 0), which updates the release/shift/control flags and may queue one ASCII
// character, or a read (mode 1), which returns the oldest queued character. Every item
// yields exactly one response carrying the queue fill after the step and an overflow flag
// for a character dropped on a full queue. One item is taken per clock while the response
// side keeps up. An item accepted into the input register passes through the decode and
// queue update into the output register at the edge where it fires, which needs the output
// register free or being read. The queue is a single-write, single-read memory whose
// registered read port loads on the same edge as the output register. A response held by
// rsp_ready low stalls the input once the input register is full.
`include "assert_macros.svh"

module ps2_scan_code_to_ascii_queue_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ps2sc_pkg::req_type req_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ps2sc_pkg::rsp_type rsp_item
);

   logic                    in_v_ff, in_v_in;
   ps2sc_pkg::req_type      in_item_ff;
   logic                    out_v_ff, out_v_in;
   logic                    out_rv_ff;
   logic [7:0]              out_count_ff;
   logic                    out_ovf_ff;
   logic                    out_free, fire;
   ps2sc_pkg::push_type     push;
   ps2sc_pkg::q_status_type status;
   logic [7:0]              rd_data_ff;

   assign out_free  = !out_v_ff || rsp_ready;
   assign fire      = in_v_ff && out_free;
   assign req_ready = !in_v_ff || fire;

   always_comb begin
      in_v_in = in_v_ff;
      if (req_ready) begin
         in_v_in = req_valid;
      end
      out_v_in = out_v_ff;
      if (out_free) begin
         out_v_in = fire;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         in_v_ff  <= in_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
      if (fire) begin
         out_rv_ff    <= status.read_valid;
         out_count_ff <= 8'(status.count);
         out_ovf_ff   <= status.overflow;
      end
   end

   ps2sc_decode u_decode (
      .clock (clock),
      .reset (reset),
      .fire  (fire && !in_item_ff.mode),
      .code  (in_item_ff.scan_code),
      .push  (push)
   );

   ps2sc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .pop        (in_item_ff.mode),
      .push       (push),
      .status     (status),
      .rd_data_ff (rd_data_ff)
   );

   assign rsp_valid            = out_v_ff;
   assign rsp_item.read_valid  = out_rv_ff;
   assign rsp_item.read_char   = out_rv_ff ? rd_data_ff : 8'h00;
   assign rsp_item.queue_count = out_count_ff;
   assign rsp_item.overflow    = out_ovf_ff;

   `ASSERT_IMPLIES(a_count_bound, in_v_ff, status.count <= ps2sc_pkg::CNT_W'(ps2sc_pkg::QUEUE_DEPTH), "queue count above depth")
   `ASSERT_IMPLIES(a_ovf_full, rsp_valid && rsp_item.overflow, rsp_item.queue_count == 8'(ps2sc_pkg::QUEUE_DEPTH), "overflow with queue not full")
   `ASSERT_IMPLIES(a_ovf_not_read, rsp_valid && rsp_item.read_valid, !rsp_item.overflow, "overflow on a read item")
   `ASSERT_IMPLIES(a_stall_cause, !req_ready, rsp_valid && !rsp_ready && in_v_ff, "input stalled without output backpressure")

endmodule
